FILE: rtl/bis_pkg.sv
// Package for the bilinear image scaler.
// Fixed field widths, register map, action codes and shared structs.
// No dependencies; every other file refers to it by scoped names.
package bis_pkg;

   localparam int SIZE_W     = 9;
   localparam int STEP_W     = 24;
   localparam int COORD_W    = 12;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_INV_STEP   = 2'd2;

   localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = 9'd256;
   localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = 9'd256;
   localparam logic [STEP_W-1:0] INV_STEP_RST   = 24'd65536;

   localparam logic ACT_WRITE   = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] src_width;
      logic [SIZE_W-1:0] src_height;
      logic [STEP_W-1:0] inv_step;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic is_write;
      logic wen;
   } job_ctl_type;

endpackage

FILE: rtl/bis_csr.sv
// Configuration registers of the bilinear image scaler, APB-style access.
// Uses bis_pkg for the register map, reset values and cfg_type.
module bis_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bis_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bis_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bis_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output bis_pkg::cfg_type                   cfg
);

   bis_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= bis_pkg::SRC_WIDTH_RST;
         cfg_ff.src_height <= bis_pkg::SRC_HEIGHT_RST;
         cfg_ff.inv_step   <= bis_pkg::INV_STEP_RST;
      end else if (wr_en) begin
         case (reg_sel)
            bis_pkg::REG_SRC_WIDTH:  cfg_ff.src_width  <= pwdata[bis_pkg::SIZE_W-1:0];
            bis_pkg::REG_SRC_HEIGHT: cfg_ff.src_height <= pwdata[bis_pkg::SIZE_W-1:0];
            bis_pkg::REG_INV_STEP:   cfg_ff.inv_step   <= pwdata[bis_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         bis_pkg::REG_SRC_WIDTH:  prdata = bis_pkg::CSR_DATA_W'(cfg_ff.src_width);
         bis_pkg::REG_SRC_HEIGHT: prdata = bis_pkg::CSR_DATA_W'(cfg_ff.src_height);
         bis_pkg::REG_INV_STEP:   prdata = bis_pkg::CSR_DATA_W'(cfg_ff.inv_step);
         default:                 prdata = '0;
      endcase
   end

endmodule

FILE: rtl/bis_addr_gen.sv
// Front pipeline of the bilinear image scaler: scale multiply, clamp,
// row mirroring, store addresses and bilinear weights. Uses bis_pkg.
module bis_addr_gen #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int FRAC_BITS      = 16,
   localparam int XW = $clog2(MAX_SRC_WIDTH),
   localparam int YW = $clog2(MAX_SRC_HEIGHT),
   localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT),
   localparam int WW = 2 * FRAC_BITS + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bis_pkg::cfg_type                  cfg,
   input  logic                              start,
   output logic                              busy,
   input  logic                              action,
   input  logic [bis_pkg::COORD_W-1:0]       coord_x,
   input  logic [bis_pkg::COORD_W-1:0]       coord_y,
   input  logic [bis_pkg::PIX_W-1:0]         pixel,
   input  logic                              job_ready,
   output bis_pkg::job_ctl_type              job_ctl,
   output logic [AW-1:0]                     job_base1,
   output logic [AW-1:0]                     job_base2,
   output logic [XW-1:0]                     job_x1,
   output logic [XW-1:0]                     job_x2,
   output logic [3:0][WW-1:0]                job_wgt,
   output logic [bis_pkg::PIX_W-1:0]         job_pixel
);

   localparam int CW   = bis_pkg::COORD_W;
   localparam int SXW  = CW + bis_pkg::STEP_W;
   localparam int IXW  = SXW - FRAC_BITS;
   localparam int CMPW = ((XW > YW ? XW : YW) > bis_pkg::SIZE_W ?
                          (XW > YW ? XW : YW) : bis_pkg::SIZE_W) + 1;
   localparam logic [FRAC_BITS:0] ONE_FIX = (FRAC_BITS+1)'(1) << FRAC_BITS;

   // effective size minus one, from the size registers
   logic [XW-1:0] wm1;
   logic [YW-1:0] hm1;

   always_comb begin
      if (cfg.src_width == '0)
         wm1 = '0;
      else if (CMPW'(cfg.src_width) > CMPW'(MAX_SRC_WIDTH))
         wm1 = XW'(MAX_SRC_WIDTH - 1);
      else
         wm1 = XW'(CMPW'(cfg.src_width) - CMPW'(1));
      if (cfg.src_height == '0)
         hm1 = '0;
      else if (CMPW'(cfg.src_height) > CMPW'(MAX_SRC_HEIGHT))
         hm1 = YW'(MAX_SRC_HEIGHT - 1);
      else
         hm1 = YW'(CMPW'(cfg.src_height) - CMPW'(1));
   end

   // stall chain
   logic p_take, a_take, b_take;
   logic pv_ff, av_ff, bv_ff;

   assign b_take = !bv_ff || job_ready;
   assign a_take = !av_ff || b_take;
   assign p_take = !pv_ff || a_take;
   assign busy   = !p_take;

   // stage P: capture word and scale coordinates
   logic                      p_act_ff;
   logic [CW-1:0]             p_cx_ff, p_cy_ff;
   logic [bis_pkg::PIX_W-1:0] p_pix_ff;
   logic [SXW-1:0]            p_sx_ff, p_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (p_take) begin
         pv_ff <= start;
      end
      if (p_take) begin
         p_act_ff <= action;
         p_cx_ff  <= coord_x;
         p_cy_ff  <= coord_y;
         p_pix_ff <= pixel;
         p_sx_ff  <= SXW'(coord_x) * SXW'(cfg.inv_step);
         p_sy_ff  <= SXW'(coord_y) * SXW'(cfg.inv_step);
      end
   end

   // stage A: clamp request neighbors to the image, bound writes to the store
   logic [IXW-1:0]       ix, iy;
   logic [XW-1:0]        x1_in, x2_in;
   logic [YW-1:0]        y1_in, y2_in;
   logic                 wen_in;
   logic                 a_write_ff, a_wen_ff;
   logic [XW-1:0]        a_x1_ff, a_x2_ff;
   logic [YW-1:0]        a_y1_ff, a_y2_ff;
   logic [FRAC_BITS-1:0] a_fx_ff, a_fy_ff;
   logic [bis_pkg::PIX_W-1:0] a_pix_ff;

   assign ix = p_sx_ff[SXW-1:FRAC_BITS];
   assign iy = p_sy_ff[SXW-1:FRAC_BITS];

   always_comb begin
      if (p_act_ff == bis_pkg::ACT_WRITE) begin
         x1_in  = p_cx_ff[XW-1:0];
         x2_in  = x1_in;
         y1_in  = p_cy_ff[YW-1:0];
         y2_in  = y1_in;
         wen_in = ((CW+1)'(p_cx_ff) < (CW+1)'(MAX_SRC_WIDTH)) &&
                  ((CW+1)'(p_cy_ff) < (CW+1)'(MAX_SRC_HEIGHT));
      end else begin
         x1_in  = (ix > IXW'(wm1)) ? wm1 : ix[XW-1:0];
         x2_in  = (x1_in == wm1) ? wm1 : x1_in + XW'(1);
         y1_in  = (iy > IXW'(hm1)) ? hm1 : iy[YW-1:0];
         y2_in  = (y1_in == hm1) ? hm1 : y1_in + YW'(1);
         wen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (a_take) begin
         av_ff <= pv_ff;
      end
      if (a_take) begin
         a_write_ff <= (p_act_ff == bis_pkg::ACT_WRITE);
         a_wen_ff   <= wen_in;
         a_x1_ff    <= x1_in;
         a_x2_ff    <= x2_in;
         a_y1_ff    <= y1_in;
         a_y2_ff    <= y2_in;
         a_fx_ff    <= p_sx_ff[FRAC_BITS-1:0];
         a_fy_ff    <= p_sy_ff[FRAC_BITS-1:0];
         a_pix_ff   <= p_pix_ff;
      end
   end

   // stage B: mirror request rows, row bases and weights
   logic [YW-1:0]        row1_in, row2_in;
   logic [FRAC_BITS:0]   fx_w, fy_w, gx_w, gy_w;
   bis_pkg::job_ctl_type b_ctl_ff;
   logic [AW-1:0]        b_base1_ff, b_base2_ff;
   logic [XW-1:0]        b_x1_ff, b_x2_ff;
   logic [3:0][WW-1:0]   b_wgt_ff;
   logic [bis_pkg::PIX_W-1:0] b_pix_ff;

   assign row1_in = a_write_ff ? a_y1_ff : hm1 - a_y1_ff;
   assign row2_in = hm1 - a_y2_ff;
   assign fx_w    = (FRAC_BITS+1)'(a_fx_ff);
   assign fy_w    = (FRAC_BITS+1)'(a_fy_ff);
   assign gx_w    = ONE_FIX - fx_w;
   assign gy_w    = ONE_FIX - fy_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
      end else if (b_take) begin
         bv_ff <= av_ff;
      end
      if (b_take) begin
         b_ctl_ff.is_write <= a_write_ff;
         b_ctl_ff.wen      <= a_wen_ff;
         b_base1_ff        <= AW'(row1_in) * AW'(MAX_SRC_WIDTH);
         b_base2_ff        <= AW'(row2_in) * AW'(MAX_SRC_WIDTH);
         b_x1_ff           <= a_x1_ff;
         b_x2_ff           <= a_x2_ff;
         b_wgt_ff[0]       <= WW'(gx_w) * WW'(gy_w);
         b_wgt_ff[1]       <= WW'(fx_w) * WW'(gy_w);
         b_wgt_ff[2]       <= WW'(gx_w) * WW'(fy_w);
         b_wgt_ff[3]       <= WW'(fx_w) * WW'(fy_w);
         b_pix_ff          <= a_pix_ff;
      end
   end

   always_comb begin
      job_ctl.valid    = bv_ff;
      job_ctl.is_write = b_ctl_ff.is_write;
      job_ctl.wen      = b_ctl_ff.wen;
   end

   assign job_base1 = b_base1_ff;
   assign job_base2 = b_base2_ff;
   assign job_x1    = b_x1_ff;
   assign job_x2    = b_x2_ff;
   assign job_wgt   = b_wgt_ff;
   assign job_pixel = b_pix_ff;

endmodule

FILE: rtl/bis_pixel_store.sv
// Pixel store of the bilinear image scaler: single-port memory and the
// sequencer that issues one write or four neighbor reads. Uses bis_pkg.
module bis_pixel_store #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int FRAC_BITS      = 16,
   localparam int XW    = $clog2(MAX_SRC_WIDTH),
   localparam int AW    = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT),
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT,
   localparam int WW    = 2 * FRAC_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bis_pkg::job_ctl_type          job_ctl,
   input  logic [AW-1:0]                 job_base1,
   input  logic [AW-1:0]                 job_base2,
   input  logic [XW-1:0]                 job_x1,
   input  logic [XW-1:0]                 job_x2,
   input  logic [3:0][WW-1:0]            job_wgt,
   input  logic [bis_pkg::PIX_W-1:0]     job_pixel,
   output logic                          job_ready,
   output logic                          rd_valid,
   output logic [1:0]                    rd_idx,
   output logic [bis_pkg::PIX_W-1:0]     rd_data,
   output logic [3:0][WW-1:0]            rd_wgt
);

   logic [bis_pkg::PIX_W-1:0] mem [DEPTH];

   logic                      act_ff, write_ff, wen_ff;
   logic [1:0]                cnt_ff;
   logic [AW-1:0]             base1_ff, base2_ff;
   logic [XW-1:0]             x1_ff, x2_ff;
   logic [3:0][WW-1:0]        wgt_ff, rd_wgt_ff;
   logic [bis_pkg::PIX_W-1:0] pix_ff, rd_data_ff;
   logic                      rd_valid_ff;
   logic [1:0]                rd_idx_ff;
   logic [AW-1:0]             addr;
   logic                      do_read, do_write;

   // a write takes a single access, a request four reads
   assign job_ready = !act_ff || write_ff || (cnt_ff == 2'd3);
   assign addr      = (cnt_ff[1] ? base2_ff : base1_ff) + AW'(cnt_ff[0] ? x2_ff : x1_ff);
   assign do_read   = act_ff && !write_ff;
   assign do_write  = act_ff && write_ff && wen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         rd_valid_ff <= do_read;
         if (job_ready) begin
            act_ff <= job_ctl.valid;
            cnt_ff <= 2'd0;
         end else begin
            cnt_ff <= cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_ready) begin
         write_ff <= job_ctl.is_write;
         wen_ff   <= job_ctl.wen;
         base1_ff <= job_base1;
         base2_ff <= job_base2;
         x1_ff    <= job_x1;
         x2_ff    <= job_x2;
         wgt_ff   <= job_wgt;
         pix_ff   <= job_pixel;
      end
      rd_idx_ff <= cnt_ff;
      // hold weights with the last neighbor word
      if (do_read && cnt_ff == 2'd3) begin
         rd_wgt_ff <= wgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[addr] <= pix_ff;
      end
      if (do_read) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_idx   = rd_idx_ff;
   assign rd_data  = rd_data_ff;
   assign rd_wgt   = rd_wgt_ff;

endmodule

FILE: rtl/bis_blend.sv
// Blend unit of the bilinear image scaler: gathers four neighbor words,
// multiplies by the weights and sums per channel. Uses bis_pkg.
module bis_blend #(
   parameter int FRAC_BITS = 16,
   localparam int WW = 2 * FRAC_BITS + 1,
   localparam int MW = WW + bis_pkg::CHAN_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_valid,
   input  logic [1:0]                        rd_idx,
   input  logic [bis_pkg::PIX_W-1:0]         rd_data,
   input  logic [3:0][WW-1:0]                rd_wgt,
   output logic                              out_strobe,
   output logic [bis_pkg::CHAN_W-1:0]        out_red,
   output logic [bis_pkg::CHAN_W-1:0]        out_green,
   output logic [bis_pkg::CHAN_W-1:0]        out_blue
);

   localparam int CH = bis_pkg::CHAN_W;

   logic [bis_pkg::PIX_W-1:0] gath_ff [3];
   logic [bis_pkg::PIX_W-1:0] nb [4];
   logic [MW-1:0]             mul_ff [3][4];
   logic [MW-1:0]             sum [3];
   logic                      mul_go, mv_ff, ov_ff;
   logic [CH-1:0]             chan_ff [3];

   assign mul_go = rd_valid && (rd_idx == 2'd3);

   always_comb begin
      nb[0] = gath_ff[0];
      nb[1] = gath_ff[1];
      nb[2] = gath_ff[2];
      nb[3] = rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         mv_ff <= mul_go;
         ov_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid && rd_idx != 2'd3) begin
         gath_ff[rd_idx] <= rd_data;
      end
      if (mul_go) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
               mul_ff[c][k] <= MW'(nb[k][bis_pkg::PIX_W-1-CH*c -: CH]) * MW'(rd_wgt[k]);
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = mul_ff[c][0] + mul_ff[c][1] + mul_ff[c][2] + mul_ff[c][3];
      end
   end

   // drop the fraction, truncating toward zero
   always_ff @(posedge clock) begin
      if (mv_ff) begin
         for (int c = 0; c < 3; c++) begin
            chan_ff[c] <= sum[c][2*FRAC_BITS +: CH];
         end
      end
   end

   assign out_strobe = ov_ff;
   assign out_red    = chan_ff[0];
   assign out_green  = chan_ff[1];
   assign out_blue   = chan_ff[2];

endmodule

FILE: rtl/bilinear_image_scaler.sv
// Top level of the bilinear image scaler.
// Instantiates bis_csr, bis_addr_gen, bis_pixel_store and bis_blend; uses bis_pkg.
//
// A word is taken at a clock edge where start is high and busy is low. A write
// word (action 0) stores one RGB pixel with a single access to the pixel store
// port; a request word (action 1) reads four neighbors through the single store
// port, one per cycle, so the store starts a new request only after the four
// reads of the last one, and takes writes at one per cycle when they follow one
// another. A request's result appears after two more address stages, job
// capture, four reads, multiply and sum, on rsp_out_* for one cycle marked by
// rsp_strobe; the receiver cannot stall, results arrive in request order. The
// store has no reset: read only pixels that were written. Write the size and
// step registers only while idle.
module bilinear_image_scaler #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int FRAC_BITS      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [bis_pkg::COORD_W-1:0]       req_coord_x,
   input  logic [bis_pkg::COORD_W-1:0]       req_coord_y,
   input  logic [bis_pkg::CHAN_W-1:0]        req_in_red,
   input  logic [bis_pkg::CHAN_W-1:0]        req_in_green,
   input  logic [bis_pkg::CHAN_W-1:0]        req_in_blue,
   output logic                              rsp_strobe,
   output logic [bis_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [bis_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [bis_pkg::CHAN_W-1:0]        rsp_out_blue,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bis_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bis_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bis_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int XW = $clog2(MAX_SRC_WIDTH);
   localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
   localparam int WW = 2 * FRAC_BITS + 1;

   bis_pkg::cfg_type          cfg;
   bis_pkg::job_ctl_type      job_ctl;
   logic                      job_ready;
   logic [AW-1:0]             job_base1, job_base2;
   logic [XW-1:0]             job_x1, job_x2;
   logic [3:0][WW-1:0]        job_wgt, rd_wgt;
   logic [bis_pkg::PIX_W-1:0] job_pixel, rd_data;
   logic                      rd_valid;
   logic [1:0]                rd_idx;

   bis_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bis_addr_gen #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_addr_gen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .start     (start),
      .busy      (busy),
      .action    (req_action),
      .coord_x   (req_coord_x),
      .coord_y   (req_coord_y),
      .pixel     ({req_in_red, req_in_green, req_in_blue}),
      .job_ready (job_ready),
      .job_ctl   (job_ctl),
      .job_base1 (job_base1),
      .job_base2 (job_base2),
      .job_x1    (job_x1),
      .job_x2    (job_x2),
      .job_wgt   (job_wgt),
      .job_pixel (job_pixel)
   );

   bis_pixel_store #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_pixel_store (
      .clock     (clock),
      .reset     (reset),
      .job_ctl   (job_ctl),
      .job_base1 (job_base1),
      .job_base2 (job_base2),
      .job_x1    (job_x1),
      .job_x2    (job_x2),
      .job_wgt   (job_wgt),
      .job_pixel (job_pixel),
      .job_ready (job_ready),
      .rd_valid  (rd_valid),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .rd_wgt    (rd_wgt)
   );

   bis_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock      (clock),
      .reset      (reset),
      .rd_valid   (rd_valid),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data),
      .rd_wgt     (rd_wgt),
      .out_strobe (rsp_strobe),
      .out_red    (rsp_out_red),
      .out_green  (rsp_out_green),
      .out_blue   (rsp_out_blue)
   );

endmodule

FILE: tb/tb_bilinear_image_scaler.sv
`timescale 1ns / 100ps
// Self-checking bench for bilinear_image_scaler: loads source pixels, requests scaled
// pixels across many geometries and checks each one against a local bilinear predictor.
// Depends on bis_pkg and the scaler RTL.
module tb_bilinear_image_scaler;

   localparam int STORE_COLS   = 256;
   localparam int STORE_ROWS   = 256;
   localparam int FRAC         = 16;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int PIPE_DRAIN   = 16;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 64;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [bis_pkg::CHAN_W-1:0] red;
      logic [bis_pkg::CHAN_W-1:0] green;
      logic [bis_pkg::CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [3:0][15:0]  addr;   // p11, p21, p12, p22
      logic [FRAC-1:0]   fx;
      logic [FRAC-1:0]   fy;
   } taps_type;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_action;
   logic [bis_pkg::COORD_W-1:0]        req_coord_x;
   logic [bis_pkg::COORD_W-1:0]        req_coord_y;
   logic [bis_pkg::CHAN_W-1:0]         req_in_red;
   logic [bis_pkg::CHAN_W-1:0]         req_in_green;
   logic [bis_pkg::CHAN_W-1:0]         req_in_blue;
   logic                               rsp_strobe;
   logic [bis_pkg::CHAN_W-1:0]         rsp_out_red;
   logic [bis_pkg::CHAN_W-1:0]         rsp_out_green;
   logic [bis_pkg::CHAN_W-1:0]         rsp_out_blue;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [bis_pkg::CSR_ADDR_W-1:0]     paddr;
   logic [bis_pkg::CSR_DATA_W-1:0]     pwdata;
   logic [bis_pkg::CSR_DATA_W-1:0]     prdata;
   logic                               pready;

   bilinear_image_scaler dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // local copy of the source image and the register file
   rgb_type                    src_pixels [STORE_COLS*STORE_ROWS];
   bit                         src_loaded [STORE_COLS*STORE_ROWS];
   logic [bis_pkg::SIZE_W-1:0] width_reg  = bis_pkg::SRC_WIDTH_RST;
   logic [bis_pkg::SIZE_W-1:0] height_reg = bis_pkg::SRC_HEIGHT_RST;
   logic [bis_pkg::STEP_W-1:0] step_reg   = bis_pkg::INV_STEP_RST;

   rgb_type expected_pixels [$];
   int      mismatch_count = 0;
   int      result_count   = 0;
   int      request_count  = 0;
   int      write_count    = 0;
   int      geometry_count = 0;
   int      cycle_count    = 0;
   bit      no_idle        = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s", what);
   endfunction

   function automatic int unsigned clamp_size(logic [bis_pkg::SIZE_W-1:0] v,
                                              int unsigned maxv);
      if (v == 0)
         return 1;
      if (v > maxv)
         return maxv;
      return v;
   endfunction

   function automatic int unsigned image_width();
      return clamp_size(width_reg, STORE_COLS);
   endfunction

   function automatic int unsigned image_height();
      return clamp_size(height_reg, STORE_ROWS);
   endfunction

   // source position, clamped neighbors with the row mirrored, and the weights
   function automatic taps_type locate_taps(logic [bis_pkg::COORD_W-1:0] cx,
                                            logic [bis_pkg::COORD_W-1:0] cy);
      taps_type                                    t;
      int unsigned                                 w, h, x1, x2, y1, y2, r1, r2;
      logic [bis_pkg::COORD_W+bis_pkg::STEP_W-1:0] sx, sy;
      longint unsigned                             ix, iy;
      w  = image_width();
      h  = image_height();
      sx = cx * step_reg;
      sy = cy * step_reg;
      ix = sx >> FRAC;
      iy = sy >> FRAC;
      t.fx = sx[FRAC-1:0];
      t.fy = sy[FRAC-1:0];
      x1 = (ix > w - 1) ? w - 1 : int'(ix);
      y1 = (iy > h - 1) ? h - 1 : int'(iy);
      x2 = (x1 + 1 >= w) ? w - 1 : x1 + 1;
      y2 = (y1 + 1 >= h) ? h - 1 : y1 + 1;
      r1 = h - 1 - y1;
      r2 = h - 1 - y2;
      t.addr[0] = r1 * STORE_COLS + x1;
      t.addr[1] = r1 * STORE_COLS + x2;
      t.addr[2] = r2 * STORE_COLS + x1;
      t.addr[3] = r2 * STORE_COLS + x2;
      return t;
   endfunction

   function automatic logic [bis_pkg::CHAN_W-1:0] weigh_channel(
         logic [3:0][bis_pkg::CHAN_W-1:0] v, longint unsigned fx, longint unsigned fy);
      longint unsigned gx, gy, sum;
      gx  = (64'd1 << FRAC) - fx;
      gy  = (64'd1 << FRAC) - fy;
      sum = v[0] * gx * gy + v[1] * fx * gy + v[2] * gx * fy + v[3] * fx * fy;
      return sum >> (2 * FRAC);
   endfunction

   function automatic rgb_type interpolate_pixel(logic [bis_pkg::COORD_W-1:0] cx,
                                                 logic [bis_pkg::COORD_W-1:0] cy);
      taps_type                         t;
      rgb_type                          p;
      rgb_type                          res;
      logic [3:0][bis_pkg::CHAN_W-1:0]  r, g, b;
      t = locate_taps(cx, cy);
      for (int i = 0; i < 4; i++) begin
         p    = src_pixels[t.addr[i]];
         r[i] = p.red;
         g[i] = p.green;
         b[i] = p.blue;
      end
      res.red   = weigh_channel(r, t.fx, t.fy);
      res.green = weigh_channel(g, t.fx, t.fy);
      res.blue  = weigh_channel(b, t.fx, t.fy);
      return res;
   endfunction

   function automatic void apply_word(logic act, logic [bis_pkg::COORD_W-1:0] cx,
                                      logic [bis_pkg::COORD_W-1:0] cy, rgb_type px);
      if (act == bis_pkg::ACT_WRITE) begin
         // drop writes outside the store
         if (cx < STORE_COLS && cy < STORE_ROWS) begin
            src_pixels[cy * STORE_COLS + cx] = px;
            src_loaded[cy * STORE_COLS + cx] = 1'b1;
         end
         write_count++;
      end else begin
         expected_pixels.push_back(interpolate_pixel(cx, cy));
         request_count++;
      end
   endfunction

   // leaves start high on return so a following word can go out without a gap
   task automatic send_word(logic act, logic [bis_pkg::COORD_W-1:0] cx,
                            logic [bis_pkg::COORD_W-1:0] cy, rgb_type px);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start        <= 1'b0;
         req_action   <= $urandom;
         req_coord_x  <= $urandom;
         req_coord_y  <= $urandom;
         req_in_red   <= $urandom;
         req_in_green <= $urandom;
         req_in_blue  <= $urandom;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_action   <= act;
      req_coord_x  <= cx;
      req_coord_y  <= cy;
      req_in_red   <= px.red;
      req_in_green <= px.green;
      req_in_blue  <= px.blue;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_word(act, cx, cy, px);
   endtask

   // load any neighbor that was never written, then ask for the pixel
   task automatic request_pixel(logic [bis_pkg::COORD_W-1:0] cx,
                                logic [bis_pkg::COORD_W-1:0] cy);
      taps_type t;
      t = locate_taps(cx, cy);
      for (int i = 0; i < 4; i++)
         if (!src_loaded[t.addr[i]])
            send_word(bis_pkg::ACT_WRITE, t.addr[i] % STORE_COLS, t.addr[i] / STORE_COLS,
                      $urandom);
      send_word(bis_pkg::ACT_REQUEST, cx, cy, $urandom);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [bis_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         bis_pkg::REG_SRC_WIDTH:  width_reg  = value[bis_pkg::SIZE_W-1:0];
         bis_pkg::REG_SRC_HEIGHT: height_reg = value[bis_pkg::SIZE_W-1:0];
         bis_pkg::REG_INV_STEP:   step_reg   = value[bis_pkg::STEP_W-1:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(logic [1:0] idx, logic [bis_pkg::CSR_DATA_W-1:0] want, int bits);
      logic [bis_pkg::CSR_DATA_W-1:0] mask;
      mask    = (64'd1 << bits) - 1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== want)
         note_mismatch($sformatf("register %0d read %h, expected %h", idx, prdata & mask, want));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_all_registers();
      csr_check(bis_pkg::REG_SRC_WIDTH, width_reg, bis_pkg::SIZE_W);
      csr_check(bis_pkg::REG_SRC_HEIGHT, height_reg, bis_pkg::SIZE_W);
      csr_check(bis_pkg::REG_INV_STEP, step_reg, bis_pkg::STEP_W);
   endtask

   // junk above each register's width must not land in it
   task automatic program_geometry(logic [bis_pkg::SIZE_W-1:0] w,
                                   logic [bis_pkg::SIZE_W-1:0] h,
                                   logic [bis_pkg::STEP_W-1:0] step);
      settle();
      csr_write(bis_pkg::REG_SRC_WIDTH, ({$urandom} << bis_pkg::SIZE_W) | w);
      csr_write(bis_pkg::REG_SRC_HEIGHT, ({$urandom} << bis_pkg::SIZE_W) | h);
      csr_write(bis_pkg::REG_INV_STEP, ({$urandom} << bis_pkg::STEP_W) | step);
      check_all_registers();
      geometry_count++;
   endtask

   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_strobe) begin
         result_count++;
         if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("pixel %h %h %h with none pending",
                                    rsp_out_red, rsp_out_green, rsp_out_blue));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_red !== want.red)
               note_mismatch($sformatf("red %h, expected %h", rsp_out_red, want.red));
            if (rsp_out_green !== want.green)
               note_mismatch($sformatf("green %h, expected %h", rsp_out_green, want.green));
            if (rsp_out_blue !== want.blue)
               note_mismatch($sformatf("blue %h, expected %h", rsp_out_blue, want.blue));
         end
      end
   end

   task automatic test_register_access();
      check_all_registers();
      // a write to the unmapped slot changes nothing
      csr_write(REG_UNUSED, $urandom);
      check_all_registers();
   endtask

   task automatic test_directed_corners();
      no_idle = 0;
      program_geometry(9'd2, 9'd2, 24'd65536);
      send_word(bis_pkg::ACT_WRITE, 0, 0, 24'h000000);
      send_word(bis_pkg::ACT_WRITE, 1, 0, 24'hFFFFFF);
      send_word(bis_pkg::ACT_WRITE, 0, 1, 24'hFF00FF);
      send_word(bis_pkg::ACT_WRITE, 1, 1, 24'h00FF00);
      request_pixel(0, 0);
      request_pixel(1, 1);
      request_pixel(12'hFFF, 12'hFFF);
      // writes past the store must not alias into row 0
      send_word(bis_pkg::ACT_WRITE, 0, 256, 24'h123456);
      send_word(bis_pkg::ACT_WRITE, 12'hFFF, 0, 24'hABCDEF);
      send_word(bis_pkg::ACT_WRITE, 256, 12'hFFF, 24'h5A5A5A);
      request_pixel(0, 1);
      request_pixel(12'hFFF, 1);
      program_geometry(9'd2, 9'd2, 24'h008000);
      request_pixel(1, 1);
      request_pixel(3, 3);
      // zero sizes act as one pixel
      program_geometry(9'd0, 9'd0, 24'hFFFFFF);
      request_pixel(12'hFFF, 12'hFFF);
      request_pixel(0, 0);
      // zero step pins every request to the origin
      program_geometry(9'd2, 9'd2, 24'd0);
      request_pixel(12'hFFF, 0);
      request_pixel(123, 12'hFFF);
      // oversized dimensions saturate at the store size
      program_geometry(9'h1FF, 9'h1FF, 24'd1);
      request_pixel(12'hFFF, 12'hFFF);
      request_pixel(5, 12'h800);
   endtask

   function automatic logic [bis_pkg::SIZE_W-1:0] draw_size();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return 256;
         3:       return $urandom_range(257, 511);
         default: return $urandom_range(2, 16);
      endcase
   endfunction

   function automatic logic [bis_pkg::STEP_W-1:0] draw_step();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 24'hFFFFFF;
         2:       return 24'd65536;
         3:       return $urandom_range(1, 24'hFFFFFF);
         default: return $urandom_range(16384, 4 * 65536);
      endcase
   endfunction

   // output coordinate that lands inside the image or just past its edge
   function automatic logic [bis_pkg::COORD_W-1:0] draw_coord(int unsigned extent);
      longint unsigned top;
      if (step_reg == 0)
         return $urandom;
      top = ((longint'(extent) + 1) << FRAC) / step_reg;
      if (top > 4095)
         top = 4095;
      return $urandom_range(0, int'(top));
   endfunction

   task automatic test_random_scaling();
      int roll;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            program_geometry(9'd256, 9'd256, 24'd65536);
         else if (phase == 1)
            program_geometry(9'd1, 9'd1, 24'hFFFFFF);
         else
            program_geometry(draw_size(), draw_size(), draw_step());
         no_idle = (phase % 3 == 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
               request_pixel(draw_coord(image_width()), draw_coord(image_height()));
            else if (roll < 75)
               request_pixel($urandom, $urandom);
            else if (roll < 92)
               send_word(bis_pkg::ACT_WRITE, $urandom_range(0, image_width() - 1),
                         $urandom_range(0, image_height() - 1), $urandom);
            else
               send_word(bis_pkg::ACT_WRITE, $urandom, $urandom, $urandom);
         end
      end
      no_idle = 0;
   endtask

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_action   <= bis_pkg::ACT_WRITE;
      req_coord_x  <= '0;
      req_coord_y  <= '0;
      req_in_red   <= '0;
      req_in_green <= '0;
      req_in_blue  <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_directed_corners();
      test_random_scaling();
      settle();

      $display("covered %0d pixel writes and %0d scaled requests over %0d geometries",
               write_count, request_count, geometry_count);
      $display("%0d pixels checked, %0d mismatches", result_count, mismatch_count);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
